// ===== sv/mme_pkg.sv =====
// Package for the MIDI message encoder: transaction payload structs, message
// kind codes and MIDI byte constants. No dependencies.
package mme_pkg;

    typedef enum logic [4:0] {
        FUNC_NOTE_OFF     = 5'd0,
        FUNC_NOTE_ON      = 5'd1,
        FUNC_KEY_PRESS    = 5'd2,
        FUNC_CTRL_CHANGE  = 5'd3,
        FUNC_PROGRAM      = 5'd4,
        FUNC_CHAN_PRESS   = 5'd5,
        FUNC_PITCH_BEND   = 5'd6,
        FUNC_SOUND_OFF    = 5'd7,
        FUNC_RESET_CTRLS  = 5'd8,
        FUNC_LOCAL_CTRL   = 5'd9,
        FUNC_NOTES_OFF    = 5'd10,
        FUNC_OMNI_MODE    = 5'd11,
        FUNC_POLY_MODE    = 5'd12,
        FUNC_SYSEX_BEGIN  = 5'd13,
        FUNC_SYSEX_DATA   = 5'd14,
        FUNC_SYSEX_END    = 5'd15,
        FUNC_QFRAME       = 5'd16,
        FUNC_SONG_POS     = 5'd17,
        FUNC_SONG_SEL     = 5'd18,
        FUNC_TUNE         = 5'd19,
        FUNC_START        = 5'd20,
        FUNC_CONTINUE     = 5'd21,
        FUNC_STOP         = 5'd22,
        FUNC_SYS_RESET    = 5'd23
    } t_func;

    localparam logic [3:0] ST_CTRL_CHANGE = 4'hB;
    localparam logic [3:0] ST_PITCH_BEND  = 4'hE;
    localparam logic [7:0] ST_SYSEX_BEGIN = 8'hF0;
    localparam logic [7:0] ST_QFRAME      = 8'hF1;
    localparam logic [7:0] ST_SONG_POS    = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
    localparam logic [7:0] ST_TUNE        = 8'hF6;
    localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
    localparam logic [7:0] ST_START       = 8'hFA;
    localparam logic [7:0] ST_CONTINUE    = 8'hFB;
    localparam logic [7:0] ST_STOP        = 8'hFC;
    localparam logic [7:0] ST_SYS_RESET   = 8'hFF;

    localparam logic [6:0] CC_SOUND_OFF   = 7'd120;
    localparam logic [6:0] CC_RESET_CTRLS = 7'd121;
    localparam logic [6:0] CC_LOCAL_CTRL  = 7'd122;
    localparam logic [6:0] CC_NOTES_OFF   = 7'd123;
    localparam logic [6:0] CC_OMNI_OFF    = 7'd124;
    localparam logic [6:0] CC_OMNI_ON     = 7'd125;
    localparam logic [6:0] CC_MONO_ON     = 7'd126;
    localparam logic [6:0] CC_POLY_ON     = 7'd127;
    localparam logic [6:0] DATA_MAX       = 7'h7F;

    localparam int unsigned MAX_BYTES = 4;

    typedef struct packed {
        logic [4:0]  func;
        logic [3:0]  channel;
        logic [6:0]  first_value;
        logic [6:0]  second_value;
        logic [20:0] wide_value;
        logic        switch_on;
        logic [7:0]  data_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_out;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                count;
    } t_enc;

endpackage

// ===== sv/mme_encode.sv =====
// Message encoder: turns one request into up to four stream bytes and keeps
// the running status byte. Depends on mme_pkg.
module mme_encode import mme_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_item,
    input  logic i_take,
    output t_enc o_enc
);

    logic [7:0]      r_status;
    logic [7:0]      n_status;
    logic [7:0]      status;
    logic            use_status;
    logic            put_status;
    logic [2:0][7:0] extra;
    logic [1:0]      extra_cnt;
    logic [20:0]     v;
    logic [1:0]      idx;
    t_enc            enc;

    assign v = i_item.wide_value;

    always_comb begin
        status     = '0;
        use_status = 1'b0;
        extra      = '0;
        extra_cnt  = 2'd0;
        unique case (t_func'(i_item.func))
            FUNC_NOTE_OFF, FUNC_NOTE_ON, FUNC_KEY_PRESS, FUNC_CTRL_CHANGE: begin
                status     = {1'b1, i_item.func[2:0], i_item.channel};
                use_status = 1'b1;
                extra[0]   = {1'b0, i_item.first_value};
                extra[1]   = {1'b0, i_item.second_value};
                extra_cnt  = 2'd2;
            end
            FUNC_PROGRAM, FUNC_CHAN_PRESS: begin
                status     = {1'b1, i_item.func[2:0], i_item.channel};
                use_status = 1'b1;
                extra[0]   = {1'b0, i_item.first_value};
                extra_cnt  = 2'd1;
            end
            FUNC_PITCH_BEND: begin
                status     = {ST_PITCH_BEND, i_item.channel};
                use_status = 1'b1;
                extra[0]   = {1'b0, v[6:0]};
                extra[1]   = {1'b0, v[13:7]};
                extra_cnt  = 2'd2;
            end
            FUNC_SOUND_OFF, FUNC_RESET_CTRLS, FUNC_LOCAL_CTRL, FUNC_NOTES_OFF,
            FUNC_OMNI_MODE, FUNC_POLY_MODE: begin
                status     = {ST_CTRL_CHANGE, i_item.channel};
                use_status = 1'b1;
                extra_cnt  = 2'd2;
                unique case (t_func'(i_item.func))
                    FUNC_SOUND_OFF:   extra[0] = {1'b0, CC_SOUND_OFF};
                    FUNC_RESET_CTRLS: extra[0] = {1'b0, CC_RESET_CTRLS};
                    FUNC_LOCAL_CTRL: begin
                        extra[0] = {1'b0, CC_LOCAL_CTRL};
                        extra[1] = i_item.switch_on ? {1'b0, DATA_MAX} : 8'h00;
                    end
                    FUNC_NOTES_OFF:   extra[0] = {1'b0, CC_NOTES_OFF};
                    FUNC_OMNI_MODE:
                        extra[0] = {1'b0, i_item.switch_on ? CC_OMNI_ON : CC_OMNI_OFF};
                    default:
                        extra[0] = {1'b0, i_item.switch_on ? CC_POLY_ON : CC_MONO_ON};
                endcase
            end
            FUNC_SYSEX_BEGIN: begin
                status     = ST_SYSEX_BEGIN;
                use_status = 1'b1;
                if (|v[20:14]) begin
                    extra[0]  = {1'b1, v[20:14]};
                    extra[1]  = {1'b1, v[13:7]};
                    extra[2]  = {1'b0, v[6:0]};
                    extra_cnt = 2'd3;
                end else if (|v[13:7]) begin
                    extra[0]  = {1'b1, v[13:7]};
                    extra[1]  = {1'b0, v[6:0]};
                    extra_cnt = 2'd2;
                end else begin
                    extra[0]  = {1'b0, v[6:0]};
                    extra_cnt = 2'd1;
                end
            end
            FUNC_SYSEX_DATA: begin
                extra[0]  = i_item.data_byte;
                extra_cnt = 2'd1;
            end
            FUNC_SYSEX_END: begin
                status     = ST_SYSEX_END;
                use_status = 1'b1;
            end
            FUNC_QFRAME: begin
                status     = ST_QFRAME;
                use_status = 1'b1;
                extra[0]   = {1'b0, i_item.first_value[2:0], i_item.second_value[3:0]};
                extra_cnt  = 2'd1;
            end
            FUNC_SONG_POS: begin
                status     = ST_SONG_POS;
                use_status = 1'b1;
                extra[0]   = {1'b0, v[6:0]};
                extra[1]   = {1'b0, v[13:7]};
                extra_cnt  = 2'd2;
            end
            FUNC_SONG_SEL: begin
                status     = ST_SONG_SEL;
                use_status = 1'b1;
                extra[0]   = {1'b0, i_item.first_value};
                extra_cnt  = 2'd1;
            end
            FUNC_TUNE: begin
                status     = ST_TUNE;
                use_status = 1'b1;
            end
            FUNC_START: begin
                status     = ST_START;
                use_status = 1'b1;
            end
            FUNC_CONTINUE: begin
                status     = ST_CONTINUE;
                use_status = 1'b1;
            end
            FUNC_STOP: begin
                status     = ST_STOP;
                use_status = 1'b1;
            end
            FUNC_SYS_RESET: begin
                status     = ST_SYS_RESET;
                use_status = 1'b1;
            end
            default: begin
                status     = '0;
                use_status = 1'b0;
            end
        endcase
    end

    assign put_status = use_status && (status != r_status);

    always_comb begin
        enc       = '0;
        idx       = 2'd0;
        enc.count = 3'(put_status) + 3'(extra_cnt);
        if (put_status) begin
            enc.bytes[0] = status;
        end
        for (int k = 0; k < 3; k++) begin
            idx = 2'(put_status) + 2'(k);
            if (2'(k) < extra_cnt) begin
                enc.bytes[idx] = extra[k];
            end
        end
    end

    assign o_enc    = enc;
    assign n_status = (i_take && put_status) ? status : r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= '0;
        end else begin
            r_status <= n_status;
        end
    end

endmodule

// ===== sv/mme_serial.sv =====
// Byte buffer and output register: holds the bytes of one message and hands
// them out one per transaction with the last-byte mark. Depends on mme_pkg.
module mme_serial import mme_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_enc i_enc,
    input  logic i_take,
    output logic o_can_take,
    input  logic i_out_ready,
    output logic o_out_valid,
    output t_out o_out_data
);

    logic [MAX_BYTES-1:0][7:0] r_bytes;
    logic [MAX_BYTES-1:0][7:0] n_bytes;
    logic [2:0]                r_rem;
    logic [2:0]                n_rem;
    logic                      r_out_valid;
    logic                      n_out_valid;
    t_out                      r_out;
    t_out                      n_out;
    logic                      out_load;
    logic                      emit;

    assign out_load   = !r_out_valid || i_out_ready;
    assign emit       = out_load && (r_rem != 3'd0);
    assign o_can_take = (r_rem == 3'd0) || ((r_rem == 3'd1) && out_load);

    always_comb begin
        n_bytes     = r_bytes;
        n_rem       = r_rem;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = emit;
        end
        if (emit) begin
            n_out.out_byte  = r_bytes[0];
            n_out.last_byte = (r_rem == 3'd1);
            n_bytes         = {8'h00, r_bytes[MAX_BYTES-1:1]};
            n_rem           = r_rem - 3'd1;
        end
        if (i_take) begin
            n_bytes = i_enc.bytes;
            n_rem   = i_enc.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rem       <= n_rem;
            r_out_valid <= n_out_valid;
        end
        r_bytes <= n_bytes;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== sv/midi_message_encoder_core.sv =====
// MIDI message encoder top level with running status and valid/ready channels.
// A message's bytes are registered in the message buffer, then in the output
// register. Throughput: one output byte per cycle unless the output stalls.
// The single output register drains the buffer, up to four bytes a message.
// Reset clears the running status, the buffer and the output valid.
// Depends on mme_pkg, mme_encode and mme_serial.
module midi_message_encoder_core import mme_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_enc enc;
    logic can_take;
    logic take;

    assign o_in_ready = can_take;
    assign take       = i_in_valid && can_take;

    mme_encode u_encode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in_data),
        .i_take  (take),
        .o_enc   (enc)
    );

    mme_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enc       (enc),
        .i_take      (take),
        .o_can_take  (can_take),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== sv/mme_checker.sv =====
// Port-level checks for the MIDI message encoder, bound to the top level.
// Depends on mme_pkg.
module mme_checker import mme_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    logic [2:0] r_run;
    logic [2:0] n_run;

    always_comb begin
        n_run = r_run;
        if (o_out_valid && i_out_ready) begin
            n_run = o_out_data.last_byte ? 3'd0 : r_run + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else begin
            r_run <= n_run;
        end
    end

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input transaction dropped or changed while waiting");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped before its transaction");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not idle right after reset");

    a_msg_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last_byte |-> r_run < 3'd3)
        else $error("message longer than four bytes");

endmodule

bind midi_message_encoder_core mme_checker u_mme_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for midi_message_encoder_core: directed and random MIDI
// requests against a built-in running status predictor, with random stalls.
// Depends on mme_pkg and midi_message_encoder_core.
module tb_top;
    import mme_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [4:0] FUNC_FIRST_UNUSED = 5'd24;
    localparam logic [4:0] FUNC_LAST_UNUSED  = 5'd31;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;

    t_out       expected_bytes[$];
    t_out       want;
    logic [7:0] tx_status;
    int         mismatches = 0;
    int         idle_odds = 4;
    int         stall_left = 0;

    midi_message_encoder_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_in make_item(input logic [4:0] func, input logic [3:0] channel,
                                      input logic [6:0] first_value,
                                      input logic [6:0] second_value,
                                      input logic [20:0] wide_value,
                                      input logic switch_on, input logic [7:0] data_byte);
        t_in m;
        m.func         = func;
        m.channel      = channel;
        m.first_value  = first_value;
        m.second_value = second_value;
        m.wide_value   = wide_value;
        m.switch_on    = switch_on;
        m.data_byte    = data_byte;
        return m;
    endfunction

    // Works out the bytes of one message and queues them as expected results.
    function automatic void predict_bytes(input t_in m);
        logic [7:0]  msg[$];
        logic [7:0]  status;
        logic [7:0]  d1;
        logic [7:0]  d2;
        logic [13:0] w14;
        logic [20:0] wide;
        int          len;
        t_out        res;
        status = 8'h00;
        d1 = 8'h00;
        d2 = 8'h00;
        len = 0;
        w14 = m.wide_value[13:0];
        wide = m.wide_value;
        case (m.func)
            FUNC_NOTE_OFF, FUNC_NOTE_ON, FUNC_KEY_PRESS, FUNC_CTRL_CHANGE: begin
                status = {1'b1, m.func[2:0], m.channel};
                d1 = {1'b0, m.first_value};
                d2 = {1'b0, m.second_value};
                len = 3;
            end
            FUNC_PROGRAM, FUNC_CHAN_PRESS: begin
                status = {1'b1, m.func[2:0], m.channel};
                d1 = {1'b0, m.first_value};
                len = 2;
            end
            FUNC_PITCH_BEND: begin
                status = {ST_PITCH_BEND, m.channel};
                d1 = {1'b0, w14[6:0]};
                d2 = {1'b0, w14[13:7]};
                len = 3;
            end
            FUNC_SOUND_OFF, FUNC_RESET_CTRLS, FUNC_LOCAL_CTRL,
            FUNC_NOTES_OFF, FUNC_OMNI_MODE, FUNC_POLY_MODE: begin
                status = {ST_CTRL_CHANGE, m.channel};
                len = 3;
                case (m.func)
                    FUNC_SOUND_OFF:   d1 = {1'b0, CC_SOUND_OFF};
                    FUNC_RESET_CTRLS: d1 = {1'b0, CC_RESET_CTRLS};
                    FUNC_LOCAL_CTRL: begin
                        d1 = {1'b0, CC_LOCAL_CTRL};
                        d2 = m.switch_on ? {1'b0, DATA_MAX} : 8'h00;
                    end
                    FUNC_NOTES_OFF:   d1 = {1'b0, CC_NOTES_OFF};
                    FUNC_OMNI_MODE:   d1 = {1'b0, m.switch_on ? CC_OMNI_ON : CC_OMNI_OFF};
                    default:          d1 = {1'b0, m.switch_on ? CC_POLY_ON : CC_MONO_ON};
                endcase
            end
            FUNC_SYSEX_BEGIN: begin
                status = ST_SYSEX_BEGIN;
                len = 1;
            end
            FUNC_SYSEX_END: begin
                status = ST_SYSEX_END;
                len = 1;
            end
            FUNC_QFRAME: begin
                status = ST_QFRAME;
                d1 = {1'b0, m.first_value[2:0], m.second_value[3:0]};
                len = 2;
            end
            FUNC_SONG_POS: begin
                status = ST_SONG_POS;
                d1 = {1'b0, w14[6:0]};
                d2 = {1'b0, w14[13:7]};
                len = 3;
            end
            FUNC_SONG_SEL: begin
                status = ST_SONG_SEL;
                d1 = {1'b0, m.first_value};
                len = 2;
            end
            FUNC_TUNE:      begin status = ST_TUNE;      len = 1; end
            FUNC_START:     begin status = ST_START;     len = 1; end
            FUNC_CONTINUE:  begin status = ST_CONTINUE;  len = 1; end
            FUNC_STOP:      begin status = ST_STOP;      len = 1; end
            FUNC_SYS_RESET: begin status = ST_SYS_RESET; len = 1; end
            FUNC_SYSEX_DATA: msg.push_back(m.data_byte);
            default: ;
        endcase
        if (len > 0) begin
            if (status != tx_status) begin
                tx_status = status;
                msg.push_back(status);
            end
            if (len > 1) msg.push_back(d1);
            if (len > 2) msg.push_back(d2);
        end
        if (m.func == FUNC_SYSEX_BEGIN) begin
            if (wide >= 21'h4000) begin
                msg.push_back({1'b1, wide[20:14]});
                msg.push_back({1'b1, wide[13:7]});
            end else if (wide >= 21'h80) begin
                msg.push_back({1'b1, wide[13:7]});
            end
            msg.push_back({1'b0, wide[6:0]});
        end
        foreach (msg[i]) begin
            res.out_byte  = msg[i];
            res.last_byte = (i == msg.size() - 1);
            expected_bytes.push_back(res);
        end
    endfunction

    task automatic send_request(input t_in m);
        i_in_valid <= 1'b1;
        i_in_data  <= m;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_bytes(m);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (i_rst_n && idle_odds != 0 && $urandom_range(1, 2 * idle_odds) == 1) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 5);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_bytes.size() == 0) begin
                $error("out_byte: expected none, actual %h", o_out_data.out_byte);
                mismatches++;
            end else begin
                want = expected_bytes.pop_front();
                if (o_out_data.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %h, actual %h", want.out_byte,
                           o_out_data.out_byte);
                    mismatches++;
                end
                if (o_out_data.last_byte !== want.last_byte) begin
                    $error("last_byte: expected %b, actual %b", want.last_byte,
                           o_out_data.last_byte);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_voice_messages();
        send_request(make_item(FUNC_NOTE_OFF, 4'd0, 7'd0, 7'd0, 21'd0, 1'b0, 8'h00));
        send_request(make_item(FUNC_NOTE_ON, 4'd15, 7'd127, 7'd127, 21'd0, 1'b0, 8'h00));
        send_request(make_item(FUNC_NOTE_ON, 4'd15, 7'h55, 7'h2A, 21'd0, 1'b0, 8'h00));
        send_request(make_item(FUNC_KEY_PRESS, 4'd9, 7'd60, 7'd100, 21'd0, 1'b0, 8'h00));
        send_request(make_item(FUNC_CTRL_CHANGE, 4'd5, 7'd7, 7'd64, 21'd0, 1'b0, 8'h00));
        send_request(make_item(FUNC_PROGRAM, 4'd15, 7'd127, 7'd0, 21'd0, 1'b0, 8'h00));
        send_request(make_item(FUNC_CHAN_PRESS, 4'd1, 7'd0, 7'd127, 21'd0, 1'b0, 8'h00));
        send_request(make_item(FUNC_PITCH_BEND, 4'd2, 7'd0, 7'd0, 21'h1FFFFF, 1'b0, 8'h00));
        send_request(make_item(FUNC_PITCH_BEND, 4'd2, 7'd0, 7'd0, 21'd0, 1'b0, 8'h00));
    endtask

    task automatic test_mode_controls();
        send_request(make_item(FUNC_SOUND_OFF, 4'd3, 7'd0, 7'd0, 21'd0, 1'b0, 8'h00));
        send_request(make_item(FUNC_RESET_CTRLS, 4'd3, 7'd0, 7'd0, 21'd0, 1'b0, 8'h00));
        send_request(make_item(FUNC_LOCAL_CTRL, 4'd3, 7'd0, 7'd0, 21'd0, 1'b1, 8'h00));
        send_request(make_item(FUNC_NOTES_OFF, 4'd12, 7'd0, 7'd0, 21'd0, 1'b0, 8'h00));
        send_request(make_item(FUNC_OMNI_MODE, 4'd12, 7'd0, 7'd0, 21'd0, 1'b0, 8'h00));
        send_request(make_item(FUNC_POLY_MODE, 4'd12, 7'd0, 7'd0, 21'd0, 1'b1, 8'h00));
    endtask

    task automatic test_system_messages();
        send_request(make_item(FUNC_QFRAME, 4'd0, 7'd127, 7'd127, 21'd0, 1'b0, 8'h00));
        send_request(make_item(FUNC_SONG_POS, 4'd0, 7'd0, 7'd0, 21'h1FFFFF, 1'b0, 8'h00));
        send_request(make_item(FUNC_SONG_SEL, 4'd0, 7'd127, 7'd0, 21'd0, 1'b0, 8'h00));
        send_request(make_item(FUNC_TUNE, 4'd0, 7'd0, 7'd0, 21'd0, 1'b0, 8'h00));
        send_request(make_item(FUNC_TUNE, 4'd0, 7'd0, 7'd0, 21'd0, 1'b0, 8'h00));
        send_request(make_item(FUNC_START, 4'd0, 7'd0, 7'd0, 21'd0, 1'b0, 8'h00));
        send_request(make_item(FUNC_CONTINUE, 4'd0, 7'd0, 7'd0, 21'd0, 1'b0, 8'h00));
        send_request(make_item(FUNC_STOP, 4'd0, 7'd0, 7'd0, 21'd0, 1'b0, 8'h00));
        send_request(make_item(FUNC_SYS_RESET, 4'd0, 7'd0, 7'd0, 21'd0, 1'b0, 8'h00));
    endtask

    task automatic test_sysex_transfer();
        send_request(make_item(FUNC_SYSEX_BEGIN, 4'd0, 7'd0, 7'd0, 21'h1FFFFF, 1'b0, 8'h00));
        send_request(make_item(FUNC_SYSEX_DATA, 4'd0, 7'd0, 7'd0, 21'd0, 1'b0, 8'hFF));
        send_request(make_item(FUNC_SYSEX_DATA, 4'd0, 7'd0, 7'd0, 21'd0, 1'b0, 8'h00));
        send_request(make_item(FUNC_SYSEX_END, 4'd0, 7'd0, 7'd0, 21'd0, 1'b0, 8'h00));
        send_request(make_item(FUNC_SYSEX_DATA, 4'd0, 7'd0, 7'd0, 21'd0, 1'b0, 8'h5A));
        send_request(make_item(FUNC_SYSEX_END, 4'd0, 7'd0, 7'd0, 21'd0, 1'b0, 8'h00));
        send_request(make_item(FUNC_SYSEX_BEGIN, 4'd0, 7'd0, 7'd0, 21'h3FFF, 1'b0, 8'h00));
        send_request(make_item(FUNC_SYSEX_BEGIN, 4'd0, 7'd0, 7'd0, 21'h4000, 1'b0, 8'h00));
    endtask

    task automatic test_unused_kinds();
        send_request(make_item(FUNC_LAST_UNUSED, 4'd15, 7'd127, 7'd127, 21'h1FFFFF, 1'b1,
                               8'hFF));
        send_request(make_item(FUNC_FIRST_UNUSED, 4'd0, 7'd0, 7'd0, 21'd0, 1'b0, 8'h00));
    endtask

    function automatic logic [20:0] random_wide();
        case ($urandom_range(0, 3))
            0: return 21'($urandom_range(0, 21'h7F));
            1: return 21'($urandom_range(21'h80, 21'h3FFF));
            2: return 21'($urandom_range(21'h4000, 21'h1FFFFF));
            default: begin
                case ($urandom_range(0, 5))
                    0: return 21'h7F;
                    1: return 21'h80;
                    2: return 21'h3FFF;
                    3: return 21'h4000;
                    4: return 21'h0;
                    default: return 21'h1FFFFF;
                endcase
            end
        endcase
    endfunction

    function automatic t_in random_item(input logic [4:0] func, input logic [3:0] channel);
        return make_item(func, channel, 7'($urandom_range(0, 127)),
                         7'($urandom_range(0, 127)), random_wide(),
                         1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endfunction

    // Mostly well-formed traffic: single messages, running status bursts on one
    // channel and sysex transfers, with some unused kinds and unterminated sysex.
    task automatic test_random_traffic(input int count);
        int         sent;
        int         pick;
        int         reps;
        logic [4:0] func;
        logic [3:0] channel;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            channel = 4'($urandom_range(0, 15));
            if (pick < 12) begin
                send_request(random_item(FUNC_SYSEX_BEGIN, channel));
                reps = $urandom_range(0, 4);
                repeat (reps) send_request(random_item(FUNC_SYSEX_DATA, channel));
                sent += reps + 1;
                if ($urandom_range(0, 7) != 0) begin
                    send_request(random_item(FUNC_SYSEX_END, channel));
                    sent++;
                end
            end else if (pick < 30) begin
                func = 5'($urandom_range(FUNC_NOTE_OFF, FUNC_SYS_RESET));
                reps = $urandom_range(2, 5);
                repeat (reps) send_request(random_item(func, channel));
                sent += reps;
            end else if (pick < 34) begin
                send_request(random_item(5'($urandom_range(FUNC_FIRST_UNUSED,
                                                           FUNC_LAST_UNUSED)), channel));
            end else begin
                send_request(random_item(5'($urandom_range(FUNC_NOTE_OFF, FUNC_SYS_RESET)),
                                         channel));
                sent++;
            end
        end
    endtask

    task automatic test_mixed_pacing();
        repeat (6) begin
            case ($urandom_range(0, 3))
                0: idle_odds = 0;
                1: idle_odds = 2;
                2: idle_odds = 4;
                default: idle_odds = 8;
            endcase
            test_random_traffic(60);
        end
    endtask

    task automatic test_back_to_back();
        idle_odds = 0;
        test_random_traffic(70);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_ready <= 1'b1;
        tx_status = 8'h00;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_voice_messages();
        test_mode_controls();
        test_system_messages();
        test_sysex_transfer();
        test_unused_kinds();
        test_mixed_pacing();
        test_back_to_back();
        i_in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
